// ===== rtl/b64d_pkg.sv =====
// Shared types and constants for the base64 stream decoder.
// Used by the front end, the job queue, the back end and the top level.
package b64d_pkg;

  localparam int JOB_DEPTH = 4;

  localparam logic [1:0] ST_DATA    = 2'd0;
  localparam logic [1:0] ST_BADCHAR = 2'd1;
  localparam logic [1:0] ST_LENGTH  = 2'd2;

  typedef struct packed {
    logic [7:0] in_char;
    logic       msg_end;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       run_last;
    logic       msg_last;
  } result_t;

  // One classified input that yields results: up to three bytes or one error.
  typedef struct packed {
    logic [23:0] block;
    logic [1:0]  count;
    logic [1:0]  status;
    logic        msg_end;
  } job_t;

endpackage

// ===== rtl/b64d_front.sv =====
// Front end: classifies characters, gathers sextets and builds result jobs.
// Depends on b64d_pkg.
module b64d_front import b64d_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  accept,
  input  item_t item,
  output logic  job_push,
  output job_t  job
);

  typedef struct packed {
    logic       is_pad;
    logic       is_bad;
    logic [5:0] sextet;
  } code_t;

  function automatic code_t classify(input logic [7:0] c);
    code_t r;
    r = '{is_pad: 1'b0, is_bad: 1'b0, sextet: 6'd0};
    if (c >= 8'h41 && c <= 8'h5A)      r.sextet = 6'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7A) r.sextet = 6'(c - 8'h61 + 8'd26);
    else if (c >= 8'h30 && c <= 8'h39) r.sextet = 6'(c - 8'h30 + 8'd52);
    else if (c == 8'h2B)               r.sextet = 6'd62;
    else if (c == 8'h2F)               r.sextet = 6'd63;
    else if (c == 8'h3D)               r.is_pad = 1'b1;
    else                               r.is_bad = 1'b1;
    return r;
  endfunction

  logic [1:0]  group_pos, group_pos_next;
  logic [17:0] sextet_accum, sextet_accum_next;
  logic        pad_seen, pad_seen_next;
  logic        discarding, discarding_next;

  code_t code;
  logic  bad;
  logic  last_char;

  always_comb begin
    code = classify(item.in_char);
    last_char = item.msg_end;
    bad = code.is_bad;
    if (code.is_pad) begin
      if (group_pos < 2'd2) bad = 1'b1;
    end else if (pad_seen && group_pos == 2'd3) begin
      bad = 1'b1;   // data after a pad at position 2
    end

    group_pos_next    = group_pos;
    sextet_accum_next = sextet_accum;
    pad_seen_next     = pad_seen;
    discarding_next   = discarding;
    job_push          = 1'b0;
    job               = '{block: 24'd0, count: 2'd1, status: ST_DATA, msg_end: 1'b1};

    if (accept) begin
      if (discarding) begin
        if (last_char) begin
          group_pos_next    = 2'd0;
          sextet_accum_next = 18'd0;
          pad_seen_next     = 1'b0;
          discarding_next   = 1'b0;
        end
      end else if (bad) begin
        job_push          = 1'b1;
        job.status        = ST_BADCHAR;
        group_pos_next    = 2'd0;
        sextet_accum_next = 18'd0;
        pad_seen_next     = 1'b0;
        discarding_next   = !last_char;
      end else if (group_pos != 2'd3) begin
        pad_seen_next     = pad_seen | code.is_pad;
        sextet_accum_next = {sextet_accum[11:0], code.sextet};
        group_pos_next    = group_pos + 2'd1;
        if (last_char) begin
          job_push          = 1'b1;
          job.status        = ST_LENGTH;
          group_pos_next    = 2'd0;
          sextet_accum_next = 18'd0;
          pad_seen_next     = 1'b0;
        end
      end else begin
        job_push    = 1'b1;
        job.block   = {sextet_accum, code.sextet};
        job.msg_end = last_char;
        if (pad_seen)         job.count = 2'd1;
        else if (code.is_pad) job.count = 2'd2;
        else                  job.count = 2'd3;
        group_pos_next    = 2'd0;
        sextet_accum_next = 18'd0;
        pad_seen_next     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_pos    <= 2'd0;
      sextet_accum <= 18'd0;
      pad_seen     <= 1'b0;
      discarding   <= 1'b0;
    end else begin
      group_pos    <= group_pos_next;
      sextet_accum <= sextet_accum_next;
      pad_seen     <= pad_seen_next;
      discarding   <= discarding_next;
    end
  end

endmodule

// ===== rtl/b64d_job_fifo.sv =====
// Short job queue between the front end and the back end.
// Depends on b64d_pkg.
module b64d_job_fifo import b64d_pkg::*; #(
  parameter int DEPTH = JOB_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_job,
  output logic full,
  input  logic rd_en,
  output job_t rd_job,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;

  assign full   = (fill == CW'(DEPTH));
  assign empty  = (fill == '0);
  assign rd_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (rd_en) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (wr_en && !rd_en)      fill <= fill + CW'(1);
      else if (rd_en && !wr_en) fill <= fill - CW'(1);
    end
  end

endmodule

// ===== rtl/b64d_back.sv =====
// Back end: expands jobs into result transactions, one per cycle unless pop stalls the output, into an output register.
// Depends on b64d_pkg.
module b64d_back import b64d_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  job_t    job,
  input  logic    job_empty,
  output logic    job_pop,
  output result_t result,
  output logic    empty,
  input  logic    pop
);

  logic       cur_valid;
  job_t       cur;
  logic [1:0] idx;
  logic       out_valid;
  logic       out_free, emit, last;
  result_t    res_next;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  assign emit     = cur_valid && out_free;
  assign last     = (idx == cur.count - 2'd1);
  assign job_pop  = (!cur_valid || (emit && last)) && !job_empty;

  always_comb begin
    case (idx)
      2'd0:    res_next.out_byte = cur.block[23:16];
      2'd1:    res_next.out_byte = cur.block[15:8];
      default: res_next.out_byte = cur.block[7:0];
    endcase
    res_next.status   = cur.status;
    res_next.run_last = last;
    res_next.msg_last = last && cur.msg_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (job_pop) begin
        cur_valid <= 1'b1;
        idx       <= 2'd0;
      end else if (emit) begin
        if (last) cur_valid <= 1'b0;
        else      idx <= idx + 2'd1;
      end
      if (emit)     out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) cur <= job;
    if (emit)    result <= res_next;
  end

endmodule

// ===== rtl/base64_stream_decoder.sv =====
// Base64 stream decoder top level: front end, job queue and back end.
// Depends on b64d_pkg, b64d_front, b64d_job_fifo and b64d_back.
//
// Input channel: one character per transaction with a message-end flag, taken on
// push while full is low. Output channel: a queue of results; the oldest sits on
// result while empty is low and leaves on pop.
// The front end classifies each character in the cycle it arrives and, when a
// group completes or an error shows up, writes one job into a JOB_QUEUE_DEPTH-entry
// queue. The back end turns each job into one to three result transactions, one
// per cycle unless pop stalls the output, through a single output register.
// A result that a character causes passes the queue write, the back-end load and
// the output register before it is visible. The input takes one character per
// cycle while full is low; four data characters give at most three results and
// an error only one, so the back end keeps up. The job queue depth sets how long
// the input keeps flowing while pop is held low; once it fills, full rises.
// Reset clears group state, the queue and the output register; no results remain.
module base64_stream_decoder import b64d_pkg::*; #(
  parameter int JOB_QUEUE_DEPTH = JOB_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  item_t   item,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic job_push, job_pop, job_empty, accept;
  job_t job_in, job_out;

  assign accept = push && !full;

  b64d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .job_push (job_push),
    .job      (job_in)
  );

  b64d_job_fifo #(.DEPTH(JOB_QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_push),
    .wr_job (job_in),
    .full   (full),
    .rd_en  (job_pop),
    .rd_job (job_out),
    .empty  (job_empty)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (job_out),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

// ===== test/base64_stream_decoder_test.sv =====
// Self-checking testbench for base64_stream_decoder: directed table, then random messages.
// Depends on b64d_pkg and the decoder RTL; expected results come from the table where typed in, else from an in-bench
// decoder that tracks group position, gathered sextets, padding and error drop state.
module base64_stream_decoder_test;
  import b64d_pkg::*;

  typedef struct packed {
    logic [7:0]      ch;
    logic            last;
    logic            pinned;   // results typed in below instead of predicted
    logic [1:0]      cnt;
    result_t [2:0]   rs;
  } row_t;

  localparam result_t NONE    = '0;
  localparam result_t BAD_RES = '{out_byte: 8'h00, status: ST_BADCHAR, run_last: 1'b1,
                                  msg_last: 1'b1};
  localparam result_t LEN_RES = '{out_byte: 8'h00, status: ST_LENGTH, run_last: 1'b1,
                                  msg_last: 1'b1};

  logic    clk;
  logic    rst = 1'b1;
  logic    push;
  logic    full;
  item_t   item;
  logic    empty;
  logic    pop;
  result_t result;

  row_t    cur_row;
  bit      calm;
  int      fails;
  int      chars_sent;
  int      msgs_sent;
  int      results_checked;

  // decoder state mirrored by the predictor
  logic [1:0]  grp_pos;
  logic [17:0] accum;
  logic        pad_at2;
  logic        dropping;

  result_t fresh_results[$];
  result_t results_due[$];

  base64_stream_decoder dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function result_t res(logic [7:0] b, logic [1:0] st, logic rl, logic ml);
    res = '{out_byte: b, status: st, run_last: rl, msg_last: ml};
  endfunction

  function row_t row(logic [7:0] c, logic l);
    row = '{ch: c, last: l, pinned: 1'b0, cnt: 2'd0, rs: '0};
  endfunction

  function row_t pin(logic [7:0] c, logic l, logic [1:0] n, result_t r0, result_t r1,
                     result_t r2);
    pin = '{ch: c, last: l, pinned: 1'b1, cnt: n, rs: {r2, r1, r0}};
  endfunction

  function logic [7:0] b64_char(int v);
    if (v < 26) b64_char = 8'("A" + v);
    else if (v < 52) b64_char = 8'("a" + v - 26);
    else if (v < 62) b64_char = 8'("0" + v - 52);
    else if (v == 62) b64_char = "+";
    else b64_char = "/";
  endfunction

  function void restart_group();
    grp_pos = '0;
    accum   = '0;
    pad_at2 = 1'b0;
  endfunction

  // Predicts the results one character causes; leaves them in fresh_results.
  function void decode_char(item_t it);
    logic [5:0]  sx;
    logic        is_pad;
    logic        is_bad;
    logic [23:0] blk;
    int          n;
    fresh_results = {};
    sx = '0;
    is_pad = (it.in_char == "=");
    is_bad = 1'b0;
    if (dropping) begin
      if (it.msg_end) begin
        restart_group();
        dropping = 1'b0;
      end
      return;
    end
    if (it.in_char >= "A" && it.in_char <= "Z") sx = 6'(it.in_char - "A");
    else if (it.in_char >= "a" && it.in_char <= "z") sx = 6'(it.in_char - "a" + 26);
    else if (it.in_char >= "0" && it.in_char <= "9") sx = 6'(it.in_char - "0" + 52);
    else if (it.in_char == "+") sx = 6'd62;
    else if (it.in_char == "/") sx = 6'd63;
    else if (!is_pad) is_bad = 1'b1;
    if (is_pad && grp_pos < 2) is_bad = 1'b1;
    else if (!is_pad && !is_bad && pad_at2 && grp_pos == 2'd3) is_bad = 1'b1;
    if (is_bad) begin
      fresh_results = {fresh_results, BAD_RES};
      restart_group();
      dropping = !it.msg_end;
      return;
    end
    if (grp_pos != 2'd3) begin
      if (is_pad) pad_at2 = 1'b1;
      accum = {accum[11:0], sx};
      grp_pos = grp_pos + 2'd1;
      if (it.msg_end) begin
        fresh_results = {fresh_results, LEN_RES};
        restart_group();
      end
      return;
    end
    blk = {accum, sx};
    n = pad_at2 ? 1 : (is_pad ? 2 : 3);
    for (int k = 0; k < n; k++)
      fresh_results = {fresh_results, res(blk[23 - 8 * k -: 8], ST_DATA, k == n - 1,
                                          (k == n - 1) && it.msg_end)};
    restart_group();
  endfunction

  function void compare_output(result_t got);
    result_t want;
    if (results_due.size() == 0) begin
      $error("result with nothing pending: byte %0h status %0d", got.out_byte, got.status);
      fails++;
      return;
    end
    want = results_due.pop_front();
    results_checked++;
    if (got.out_byte !== want.out_byte) begin
      $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
      fails++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      fails++;
    end
    if (got.run_last !== want.run_last) begin
      $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
      fails++;
    end
    if (got.msg_last !== want.msg_last) begin
      $error("msg_last: expected %0b, got %0b", want.msg_last, got.msg_last);
      fails++;
    end
  endfunction

  // transaction monitor: both sides sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) compare_output(result);
      if (push && !full) begin
        decode_char(item);
        if (cur_row.pinned) begin
          for (int k = 0; k < cur_row.cnt; k++) results_due = {results_due, cur_row.rs[k]};
        end else begin
          foreach (fresh_results[k]) results_due = {results_due, fresh_results[k]};
        end
      end
    end
  end

  task send_item(row_t r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    item    <= '{in_char: r.ch, msg_end: r.last};
    cur_row <= r;
    push    <= 1'b1;
    do @(posedge clk); while (full);
    chars_sent++;
    if (r.last) msgs_sent++;
  endtask

  // One random message: mostly well formed, some cut short, corrupted or pure noise.
  task send_msg();
    logic [7:0] chs[$];
    int kind;
    int ngr;
    int padc;
    int p;
    kind = $urandom_range(0, 9);
    chs = {};
    if (kind <= 8) begin
      ngr = $urandom_range(1, 3);
      for (int g = 0; g < ngr; g++) begin
        padc = $urandom_range(0, 3);
        for (int k = 0; k < 4; k++) begin
          if ((padc == 2 && k == 3) || (padc == 3 && k >= 2)) chs = {chs, 8'("=")};
          else chs = {chs, b64_char($urandom_range(0, 63))};
        end
      end
      if (kind == 7) begin
        // message ends inside a group
        p = $urandom_range(1, 3);
        for (int k = 0; k < p; k++) chs = {chs, b64_char($urandom_range(0, 63))};
      end else if (kind == 8) begin
        p = $urandom_range(0, chs.size() - 1);
        chs[p] = $urandom_range(0, 1) ? 8'("=") : 8'($urandom_range(0, 255));
      end
    end else begin
      p = $urandom_range(1, 6);
      for (int k = 0; k < p; k++) chs = {chs, 8'($urandom_range(0, 255))};
    end
    foreach (chs[k]) send_item(row(chs[k], k == chs.size() - 1));
  endtask

  // result side: random stall bursts, none once the run turns calm
  initial begin
    pop <= 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      pop <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  initial begin
    row_t plan[$];
    rst     <= 1'b1;
    push    <= 1'b0;
    item    <= '0;
    cur_row <= '0;
    calm = 1'b0;
    fails = 0;
    chars_sent = 0;
    msgs_sent = 0;
    results_checked = 0;
    restart_group();
    dropping = 1'b0;

    plan = {
      // "TWFu" decodes to "Man"
      pin("T", 1'b0, 2'd0, NONE, NONE, NONE),
      pin("W", 1'b0, 2'd0, NONE, NONE, NONE),
      pin("F", 1'b0, 2'd0, NONE, NONE, NONE),
      pin("u", 1'b1, 2'd3, res(8'h4D, ST_DATA, 1'b0, 1'b0), res(8'h61, ST_DATA, 1'b0, 1'b0),
          res(8'h6E, ST_DATA, 1'b1, 1'b1)),
      // all ones, message keeps going
      pin("/", 1'b0, 2'd0, NONE, NONE, NONE),
      pin("/", 1'b0, 2'd0, NONE, NONE, NONE),
      pin("/", 1'b0, 2'd0, NONE, NONE, NONE),
      pin("/", 1'b0, 2'd3, res(8'hFF, ST_DATA, 1'b0, 1'b0), res(8'hFF, ST_DATA, 1'b0, 1'b0),
          res(8'hFF, ST_DATA, 1'b1, 1'b0)),
      // padded group before the end of the message
      row("Q", 1'b0), row("Q", 1'b0), row("=", 1'b0), row("=", 1'b0),
      // pad at group start, on the last character
      pin("=", 1'b1, 2'd1, BAD_RES, NONE, NONE),
      // pad in second slot, then the rest is dropped
      pin("A", 1'b0, 2'd0, NONE, NONE, NONE),
      pin("=", 1'b0, 2'd1, BAD_RES, NONE, NONE),
      pin(8'h00, 1'b0, 2'd0, NONE, NONE, NONE),
      pin(8'hFF, 1'b1, 2'd0, NONE, NONE, NONE),
      // character outside the alphabet
      pin(8'hFF, 1'b1, 2'd1, BAD_RES, NONE, NONE),
      // message ends mid-group
      pin("A", 1'b0, 2'd0, NONE, NONE, NONE),
      pin("B", 1'b1, 2'd1, LEN_RES, NONE, NONE),
      // pad in third slot followed by a data character
      pin("A", 1'b0, 2'd0, NONE, NONE, NONE),
      pin("B", 1'b0, 2'd0, NONE, NONE, NONE),
      pin("=", 1'b0, 2'd0, NONE, NONE, NONE),
      pin("C", 1'b0, 2'd1, BAD_RES, NONE, NONE),
      pin("z", 1'b1, 2'd0, NONE, NONE, NONE)
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) send_item(plan[i]);

    while (chars_sent < 110) begin
      if (chars_sent > 85) calm = 1'b1;
      send_msg();
    end
    push <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d characters in %0d messages sent, %0d results compared",
             chars_sent, msgs_sent, results_checked);
    if (fails == 0) begin
      $display("base64_stream_decoder_test: PASS");
    end else begin
      $display("base64_stream_decoder_test: FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("base64_stream_decoder_test: FAIL");
    $finish;
  end

endmodule
